// ===== src/thd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the tape hiss and dropout block.
// Depends on nothing; every other file in src takes it in.
package thd_pkg;

   // Frame layout, fixed by the port list.
   localparam int CHANNELS    = 2;
   localparam int CH_W        = 1;
   localparam int SAMPLE_BITS = 24;
   localparam int TAPS        = 7;
   localparam int POLES       = 6;
   localparam int TAP_W       = 3;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [23:0]            tap_type;
   typedef logic signed [32:0]            opnd_type;
   typedef logic signed [65:0]            prod_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_NOISE_ENABLE    = 3'd0,
      REG_DROP_ENABLE     = 3'd1,
      REG_HISS_GAIN       = 3'd2,
      REG_COLOR_MIX       = 3'd3,
      REG_DROP_FLOOR_GAIN = 3'd4,
      REG_DROP_LENGTH     = 3'd5,
      REG_MEAN_GAP        = 3'd6,
      REG_MIN_GAP         = 3'd7
   } csr_reg_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DROP,
      ST_GDRAW,
      ST_GMUL1,
      ST_GMUL2,
      ST_GFIN,
      ST_SLEW,
      ST_XMUL,
      ST_XRES,
      ST_WHITE,
      ST_PA,
      ST_PB,
      ST_PD,
      ST_PE,
      ST_PS,
      ST_BLEND,
      ST_NOISE,
      ST_OUT
   } state_type;

   localparam logic [31:0] LCG_MUL       = 32'd1664525;
   localparam logic [31:0] LCG_INC       = 32'd1013904223;
   localparam logic [31:0] LCG_SEED      = 32'h2545F491;
   localparam logic [31:0] RECIP5        = 32'hCCCCCCCD;
   localparam logic [23:0] GAP_IDLE      = 24'hFFFFFF;
   localparam logic [23:0] GAP_MAX       = 24'hFFFFFE;
   localparam logic [16:0] UNITY         = 17'd65536;
   localparam logic [15:0] MIX_PINK_ONLY = 16'd65471;

   // Pink filter coefficients, Q0.24.
   localparam logic signed [24:0] POLE [POLES] = '{
      25'sd16758090, 25'sd16665144, 25'sd16257122,
      25'sd14537458, 25'sd9227469,  -25'sd12777528
   };
   localparam logic signed [24:0] FEED [POLES] = '{
      25'sd931436,  25'sd1259565, 25'sd2581208,
      25'sd5209084, 25'sd8941454, -25'sd283501
   };
   localparam logic signed [24:0] FEED_DIRECT = 25'sd8995943;
   localparam logic signed [24:0] FEED_DELAY  = 25'sd1944916;
   localparam logic signed [24:0] PINK_SCALE  = 25'sd1845494;

endpackage

// ===== src/thd_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on thd_pkg for the operand and product types.
module thd_mul (
   input  logic               clock,
   input  thd_pkg::opnd_type  mul_a,
   input  thd_pkg::opnd_type  mul_b,
   output thd_pkg::prod_type  prod
);
   import thd_pkg::*;

   prod_type prod_ff;
   prod_type prod_in;

   // The product is registered, ready in the cycle after the operands are presented.
   assign prod_in = prod_type'(mul_a) * prod_type'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== src/tape_hiss_and_dropout.sv =====
`timescale 1ns / 1ps
// Top level of the tape hiss and dropout block: sequencer and datapath.
// Depends on thd_pkg and on thd_mul, the one shared multiplier.
//
// Each stereo frame takes one request beat and gives one response beat. The
// block works on one frame at a time, and every product passes through a
// single registered multiplier, so the time per frame follows the count of
// multiplications, which grows with white hiss, again with pink hiss, and
// with each new dropout gap that is drawn; with both enables off a frame goes
// straight from the request to the hand-over. A finished frame waits in the
// response register, so the next request beat is taken while it is still held
// by the far side; a frame is held in its last cycle only while the previous
// response beat has not yet been taken.
module tape_hiss_and_dropout #(
   parameter int SLEW_SHIFT = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  thd_pkg::sample_type  req_sample_left,
   input  thd_pkg::sample_type  req_sample_right,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output thd_pkg::sample_type  rsp_out_left,
   output thd_pkg::sample_type  rsp_out_right,
   output logic                 rsp_dropout_active,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [23:0]          csr_data
);
   import thd_pkg::*;

   // Configuration registers.
   logic        noise_enable_ff, drop_enable_ff;
   logic [15:0] hiss_gain_ff, color_mix_ff;
   logic [16:0] drop_floor_gain_ff;
   logic [19:0] drop_length_ff;
   logic [23:0] mean_gap_ff, min_gap_ff;

   // Control and dropout state.
   state_type        state_ff, state_in;
   logic [CH_W-1:0]  ch_ff, ch_in;
   logic [TAP_W-1:0] k_ff, k_in;
   logic [31:0]      lcg_ff, lcg_in;
   logic [23:0]      gap_ff, gap_in;
   logic             in_drop_ff, in_drop_in;
   logic [19:0]      rem_ff, rem_in;
   logic [16:0]      applied_ff, applied_in;
   logic [16:0]      target_ff, target_in;
   logic             gap_after_ff, gap_after_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   sample_type          x_ff [CHANNELS];
   sample_type          res_ff [CHANNELS];
   sample_type          res_in;
   logic                res_we;
   tap_type             taps_ff [CHANNELS][TAPS];
   logic                tap_we;
   logic [TAP_W-1:0]    tap_wk;
   tap_type             tap_wd;
   sample_type          y_ff, y_in;
   logic signed [20:0]  white_ff, white_in;
   logic signed [25:0]  acc_ff, acc_in;
   logic signed [27:0]  sum_ff, sum_in;
   sample_type          rsp_left_ff, rsp_right_ff;
   logic                rsp_drop_ff;

   // Shared multiplier.
   opnd_type mul_a, mul_b;
   prod_type prod, prod_rsum;
   logic signed [41:0] rnd;

   logic accept, last_ch, need_gap, rsp_free;

   thd_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign last_ch  = (ch_ff == CH_W'(CHANNELS - 1));
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign need_gap = drop_enable_ff &&
                     ((!in_drop_ff && gap_ff == GAP_IDLE) || (in_drop_ff && rem_ff <= 20'd1));

   // Q0.24 products are rounded by adding half and shifting down.
   assign prod_rsum = prod + prod_type'(66'sd8388608);
   assign rnd       = $signed(prod_rsum[65:24]);

   function automatic tap_type sat24(input logic signed [31:0] v);
      if (v > 32'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (v < -32'sd8388608) begin
         return 24'sh800000;
      end
      return v[23:0];
   endfunction

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_enable_ff    <= 1'b0;
         drop_enable_ff     <= 1'b0;
         hiss_gain_ff       <= 16'd66;
         color_mix_ff       <= 16'd0;
         drop_floor_gain_ff <= UNITY;
         drop_length_ff     <= 20'd480;
         mean_gap_ff        <= 24'hFFFFFF;
         min_gap_ff         <= 24'd960;
      end else if (csr_write) begin
         case (csr_reg_type'(csr_index))
            REG_NOISE_ENABLE:    noise_enable_ff    <= csr_data[0];
            REG_DROP_ENABLE:     drop_enable_ff     <= csr_data[0];
            REG_HISS_GAIN:       hiss_gain_ff       <= csr_data[15:0];
            REG_COLOR_MIX:       color_mix_ff       <= csr_data[15:0];
            REG_DROP_FLOOR_GAIN: drop_floor_gain_ff <= csr_data[16:0];
            REG_DROP_LENGTH:     drop_length_ff     <= csr_data[19:0];
            REG_MEAN_GAP:        mean_gap_ff        <= csr_data;
            REG_MIN_GAP:         min_gap_ff         <= csr_data;
            default: ;
         endcase
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (!noise_enable_ff && !drop_enable_ff) ? ST_OUT : ST_DROP;
            end
         end
         ST_DROP:  state_in = need_gap ? ST_GDRAW : ST_SLEW;
         ST_GDRAW: state_in = ST_GMUL1;
         ST_GMUL1: state_in = ST_GMUL2;
         ST_GMUL2: state_in = ST_GFIN;
         ST_GFIN:  state_in = ST_SLEW;
         ST_SLEW:  state_in = ST_XMUL;
         ST_XMUL:  state_in = ST_XRES;
         ST_XRES: begin
            if (noise_enable_ff) begin
               state_in = ST_WHITE;
            end else begin
               state_in = last_ch ? ST_OUT : ST_XMUL;
            end
         end
         ST_WHITE: state_in = (color_mix_ff == 16'd0) ? ST_NOISE : ST_PA;
         ST_PA:    state_in = ST_PB;
         ST_PB:    state_in = (k_ff == TAP_W'(POLES - 1)) ? ST_PD : ST_PA;
         ST_PD:    state_in = ST_PE;
         ST_PE:    state_in = ST_PS;
         ST_PS:    state_in = (color_mix_ff >= MIX_PINK_ONLY) ? ST_NOISE : ST_BLEND;
         ST_BLEND: state_in = ST_NOISE;
         ST_NOISE: state_in = last_ch ? ST_OUT : ST_XMUL;
         ST_OUT:   state_in = rsp_free ? ST_IDLE : ST_OUT;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and multiplier operands for each state.
   always_comb begin
      logic [31:0]        lcg_new;
      logic [26:0]        q;
      logic [24:0]        gq;
      logic [24:0]        lo;
      logic [23:0]        g;
      logic               countdown;
      logic signed [18:0] diff, step, gsum;
      logic signed [31:0] v;
      logic signed [25:0] pink, mixv;
      logic [TAP_W-1:0]   k_next;

      lcg_new    = prod[31:0] + LCG_INC;
      q          = 27'({mean_gap_ff, 2'b00}) + 27'(prod[55:31]);
      gq         = prod[58:34];
      lo         = (min_gap_ff == 24'd0) ? 25'd1 : {1'b0, min_gap_ff};
      g          = gap_ff;
      countdown  = 1'b0;
      diff       = $signed({2'b00, target_ff}) - $signed({2'b00, applied_ff});
      step       = diff >>> SLEW_SHIFT;
      gsum       = $signed({2'b00, applied_ff}) + step;
      v          = '0;
      pink       = $signed(rnd[25:0]);
      mixv       = '0;
      k_next     = k_ff + TAP_W'(1);

      mul_a        = '0;
      mul_b        = '0;
      ch_in        = ch_ff;
      k_in         = k_ff;
      lcg_in       = lcg_ff;
      gap_in       = gap_ff;
      in_drop_in   = in_drop_ff;
      rem_in       = rem_ff;
      applied_in   = applied_ff;
      target_in    = target_ff;
      gap_after_in = gap_after_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      y_in         = y_ff;
      white_in     = white_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      res_we       = 1'b0;
      res_in       = y_ff;
      tap_we       = 1'b0;
      tap_wk       = k_ff;
      tap_wd       = '0;

      case (state_ff)
         ST_IDLE: begin
            ch_in = '0;
            // With the dropout machine off its state is held cleared.
            if (accept && !drop_enable_ff) begin
               in_drop_in = 1'b0;
               rem_in     = '0;
               target_in  = UNITY;
               gap_in     = GAP_IDLE;
            end
         end
         ST_DROP: begin
            if (drop_enable_ff && !need_gap) begin
               if (!in_drop_ff) begin
                  countdown = 1'b1;
               end else begin
                  rem_in = rem_ff - 20'd1;
               end
            end
            gap_after_in = !in_drop_ff;
         end
         ST_GDRAW: begin
            mul_a = {1'b0, lcg_ff};
            mul_b = {1'b0, LCG_MUL};
         end
         ST_GMUL1: begin
            lcg_in = lcg_new;
            mul_a  = {9'd0, mean_gap_ff};
            mul_b  = {1'b0, lcg_new};
         end
         ST_GMUL2: begin
            // floor(mean * (4 + 2r/2^32) / 5) by a reciprocal of five.
            mul_a = {6'd0, q};
            mul_b = {1'b0, RECIP5};
         end
         ST_GFIN: begin
            if (gq < lo) begin
               gq = lo;
            end
            g = (gq > {1'b0, GAP_MAX}) ? GAP_MAX : gq[23:0];
            if (gap_after_ff) begin
               countdown = 1'b1;
            end else begin
               in_drop_in = 1'b0;
               rem_in     = '0;
               target_in  = UNITY;
               gap_in     = g;
            end
         end
         ST_SLEW: begin
            applied_in = gsum[16:0];
         end
         ST_XMUL: begin
            k_in  = '0;
            mul_a = opnd_type'(x_ff[ch_ff]);
            mul_b = {16'd0, applied_ff};
         end
         ST_XRES: begin
            y_in = $signed(prod[39:16]);
            if (noise_enable_ff) begin
               mul_a = {1'b0, lcg_ff};
               mul_b = {1'b0, LCG_MUL};
            end else begin
               res_we = 1'b1;
               res_in = $signed(prod[39:16]);
               ch_in  = ch_ff + CH_W'(1);
            end
         end
         ST_WHITE: begin
            lcg_in   = lcg_new;
            white_in = 21'($signed({1'b0, lcg_new[31:11]}) - 22'sd1048576);
            sum_in   = '0;
            if (color_mix_ff == 16'd0) begin
               mul_a = opnd_type'(white_in);
               mul_b = {17'd0, hiss_gain_ff};
            end else begin
               mul_a = opnd_type'(taps_ff[ch_ff][k_ff]);
               mul_b = opnd_type'(POLE[k_ff]);
            end
         end
         ST_PA: begin
            acc_in = $signed(rnd[25:0]);
            mul_a  = opnd_type'(white_ff);
            mul_b  = opnd_type'(FEED[k_ff]);
         end
         ST_PB: begin
            v      = 32'(acc_ff) + 32'($signed(rnd[25:0]));
            tap_we = 1'b1;
            tap_wd = sat24(v);
            sum_in = sum_ff + 28'(sat24(v));
            if (k_ff == TAP_W'(POLES - 1)) begin
               mul_a = opnd_type'(white_ff);
               mul_b = opnd_type'(FEED_DIRECT);
            end else begin
               k_in  = k_next;
               mul_a = opnd_type'(taps_ff[ch_ff][k_next]);
               mul_b = opnd_type'(POLE[k_next]);
            end
         end
         ST_PD: begin
            sum_in = sum_ff + 28'(taps_ff[ch_ff][TAPS-1]) + 28'($signed(rnd[25:0]));
            mul_a  = opnd_type'(white_ff);
            mul_b  = opnd_type'(FEED_DELAY);
         end
         ST_PE: begin
            tap_we = 1'b1;
            tap_wk = TAP_W'(TAPS - 1);
            tap_wd = sat24(32'($signed(rnd[25:0])));
            mul_a  = opnd_type'(sum_ff);
            mul_b  = opnd_type'(PINK_SCALE);
         end
         ST_PS: begin
            if (color_mix_ff >= MIX_PINK_ONLY) begin
               mul_a = opnd_type'(pink);
               mul_b = {17'd0, hiss_gain_ff};
            end else begin
               mul_a = opnd_type'(pink) - opnd_type'(white_ff);
               mul_b = {17'd0, color_mix_ff};
            end
         end
         ST_BLEND: begin
            mixv  = 26'(white_ff) + $signed(prod[41:16]);
            mul_a = opnd_type'(mixv);
            mul_b = {17'd0, hiss_gain_ff};
         end
         ST_NOISE: begin
            // Noise moves from Q6.20 to Q1.23 by a shift of three.
            v      = 32'(y_ff) + (32'($signed(prod[41:16])) <<< 3);
            res_we = 1'b1;
            res_in = sat24(v);
            ch_in  = ch_ff + CH_W'(1);
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase

      // Gap countdown, shared by the plain step and a freshly drawn gap.
      if (countdown) begin
         if (g <= 24'd1) begin
            gap_in     = '0;
            in_drop_in = 1'b1;
            rem_in     = drop_length_ff;
            target_in  = (drop_floor_gain_ff > UNITY) ? UNITY : drop_floor_gain_ff;
         end else begin
            gap_in = g - 24'd1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         k_ff         <= '0;
         lcg_ff       <= LCG_SEED;
         gap_ff       <= GAP_IDLE;
         in_drop_ff   <= 1'b0;
         rem_ff       <= '0;
         applied_ff   <= UNITY;
         target_ff    <= UNITY;
         gap_after_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            for (int t = 0; t < TAPS; t++) begin
               taps_ff[c][t] <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         k_ff         <= k_in;
         lcg_ff       <= lcg_in;
         gap_ff       <= gap_in;
         in_drop_ff   <= in_drop_in;
         rem_ff       <= rem_in;
         applied_ff   <= applied_in;
         target_ff    <= target_in;
         gap_after_ff <= gap_after_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tap_we) begin
            taps_ff[ch_ff][tap_wk] <= tap_wd;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      y_ff     <= y_in;
      white_ff <= white_in;
      acc_ff   <= acc_in;
      sum_ff   <= sum_in;
      if (accept) begin
         x_ff[0]   <= req_sample_left;
         x_ff[1]   <= req_sample_right;
         res_ff[0] <= req_sample_left;
         res_ff[1] <= req_sample_right;
      end else if (res_we) begin
         res_ff[ch_ff] <= res_in;
      end
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_left_ff  <= res_ff[0];
         rsp_right_ff <= res_ff[1];
         rsp_drop_ff  <= in_drop_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_left       = rsp_left_ff;
   assign rsp_out_right      = rsp_right_ff;
   assign rsp_dropout_active = rsp_drop_ff;

   // A dropout always runs with the gap counter parked at zero.
   assert property (@(posedge clock) disable iff (reset) in_drop_ff |-> gap_ff == 24'd0)
      else $error("gap counter running during a dropout");

   // The gains never exceed unity.
   assert property (@(posedge clock) disable iff (reset)
      applied_ff <= UNITY && target_ff <= UNITY)
      else $error("gain above unity");

   // A new response beat only comes out of the result hand-over state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("response raised outside hand-over");

   // The filter tap index stays within the tap row.
   assert property (@(posedge clock) disable iff (reset) k_ff < TAP_W'(TAPS))
      else $error("tap index out of range");

endmodule

// ===== tb/tape_hiss_and_dropout_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the tape hiss and dropout block.
// Depends on thd_pkg and tape_hiss_and_dropout. It predicts every response
// beat with its own fixed-point model of the dropout machine, slew and hiss.
module tape_hiss_and_dropout_tb;
   import thd_pkg::*;

   localparam int  HOLD_CYCLES = 64;
   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  SLEW        = 6;
   localparam longint TAP_HI   = 8388607;
   localparam longint TAP_LO   = -8388608;

   typedef struct packed {
      sample_type left;
      sample_type right;
      logic       dropout;
   } frame_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   sample_type  req_sample_left = '0;
   sample_type  req_sample_right = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   sample_type  rsp_out_left;
   sample_type  rsp_out_right;
   logic        rsp_dropout_active;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          errors = 0;
   int          cycles = 0;
   frame_type   expected_frames[$];

   // Predictor copy of the registers.
   int unsigned cfg_noise, cfg_drop, cfg_hiss, cfg_mix, cfg_floor;
   int unsigned cfg_length, cfg_mean, cfg_min;
   // Predictor copy of the state.
   int unsigned lcg, gap_count, drop_left;
   bit          dropping;
   longint      gain_now, gain_goal;
   longint      taps [CHANNELS][TAPS];

   tape_hiss_and_dropout i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_sample_left, .req_sample_right,
      .rsp_valid, .rsp_stall, .rsp_out_left, .rsp_out_right, .rsp_dropout_active,
      .csr_write, .csr_index, .csr_data
   );

   always #4 clock = ~clock;

   // Run guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // The receiver stalls at random at the current rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Each response beat is checked against the oldest expected frame.
   always @(posedge clock) begin
      frame_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            $error("unexpected response beat");
            errors++;
         end else begin
            want = expected_frames.pop_front();
            if (rsp_out_left !== want.left) begin
               $error("out_left expected %0d got %0d", want.left, rsp_out_left);
               errors++;
            end
            if (rsp_out_right !== want.right) begin
               $error("out_right expected %0d got %0d", want.right, rsp_out_right);
               errors++;
            end
            if (rsp_dropout_active !== want.dropout) begin
               $error("dropout_active expected %0d got %0d", want.dropout,
                      rsp_dropout_active);
               errors++;
            end
         end
      end
   end

   function automatic longint sat_tap(longint v);
      return v < TAP_LO ? TAP_LO : (v > TAP_HI ? TAP_HI : v);
   endfunction

   // Q0.24 product, rounded half up.
   function automatic longint mul_q24(longint a, longint c);
      return (a * c + (64'sd1 <<< 23)) >>> 24;
   endfunction

   function automatic int unsigned lcg_next();
      lcg = lcg * 32'd1664525 + 32'd1013904223;
      return lcg;
   endfunction

   // Jittered gap: mean * (0.8 + 0.4 * r / 2^32), bounded below and above.
   function automatic int unsigned draw_gap();
      longint unsigned r, num, g, lo;
      r   = lcg_next();
      num = longint'(cfg_mean) * ((64'd4 << 32) + 2 * r);
      g   = num / (64'd5 << 32);
      lo  = (cfg_min != 0) ? cfg_min : 1;
      if (g < lo) g = lo;
      if (g > 64'hFFFFFE) g = 64'hFFFFFE;
      return int'(g);
   endfunction

   function automatic longint pink_filter(int ch, longint white);
      longint sum;
      sum = 0;
      for (int k = 0; k < POLES; k++) begin
         taps[ch][k] = sat_tap(mul_q24(taps[ch][k], POLE[k]) + mul_q24(white, FEED[k]));
         sum += taps[ch][k];
      end
      sum += taps[ch][6] + mul_q24(white, FEED_DIRECT);
      taps[ch][6] = sat_tap(mul_q24(white, FEED_DELAY));
      return mul_q24(sum, PINK_SCALE);
   endfunction

   function automatic longint hiss_sample(int ch);
      longint white, blend, pink;
      white = longint'(lcg_next() >> 11) - (64'sd1 <<< 20);
      blend = white;
      if (cfg_mix != 0) begin
         pink = pink_filter(ch, white);
         if (cfg_mix >= MIX_PINK_ONLY) blend = pink;
         else blend = white + (((pink - white) * longint'(cfg_mix)) >>> 16);
      end
      return ((blend * longint'(cfg_hiss)) >>> 16) * 8;
   endfunction

   // Advances the predictor by one frame and gives the expected output.
   function automatic frame_type predict_frame(sample_type l, sample_type r);
      frame_type f;
      longint    x, y;
      if (cfg_drop == 0) begin
         dropping  = 0;
         drop_left = 0;
         gain_goal = UNITY;
         gap_count = GAP_IDLE;
      end
      if (cfg_noise == 0 && cfg_drop == 0) begin
         f.left = l; f.right = r; f.dropout = 1'b0;
         return f;
      end
      if (cfg_drop != 0) begin
         if (!dropping) begin
            if (gap_count == GAP_IDLE) gap_count = draw_gap();
            if (gap_count <= 1) begin
               gap_count = 0;
               dropping  = 1;
               drop_left = cfg_length;
               gain_goal = cfg_floor > UNITY ? UNITY : cfg_floor;
            end else begin
               gap_count--;
            end
         end else if (drop_left <= 1) begin
            dropping  = 0;
            drop_left = 0;
            gain_goal = UNITY;
            gap_count = draw_gap();
         end else begin
            drop_left--;
         end
      end
      gain_now += (gain_goal - gain_now) >>> SLEW;
      for (int c = 0; c < CHANNELS; c++) begin
         x = (c == 0) ? longint'(l) : longint'(r);
         y = (x * gain_now) >>> 16;
         if (cfg_noise != 0) y += hiss_sample(c);
         y = sat_tap(y);
         if (c == 0) f.left = y[23:0]; else f.right = y[23:0];
      end
      f.dropout = dropping;
      return f;
   endfunction

   // Sends one frame, idling beforehand at the current rate.
   task automatic send_frame(sample_type l, sample_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_left  <= l;
      req_sample_right <= r;
      do @(posedge clock); while (req_stall);
      expected_frames.push_back(predict_frame(l, r));
   endtask

   // Lowers valid and waits until every expected frame has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (HOLD_CYCLES) @(posedge clock);
   endtask

   // One register write, with csr_write lowered again before the next one.
   task automatic write_reg(csr_reg_type idx, logic [23:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_NOISE_ENABLE:    cfg_noise  = value[0];
         REG_DROP_ENABLE:     cfg_drop   = value[0];
         REG_HISS_GAIN:       cfg_hiss   = value[15:0];
         REG_COLOR_MIX:       cfg_mix    = value[15:0];
         REG_DROP_FLOOR_GAIN: cfg_floor  = value[16:0];
         REG_DROP_LENGTH:     cfg_length = value[19:0];
         REG_MEAN_GAP:        cfg_mean   = value;
         default:             cfg_min    = value;
      endcase
   endtask

   function automatic sample_type any_sample();
      case ($urandom_range(9))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return '0;
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic test_passthrough();
      send_frame(24'h800000, 24'h7FFFFF);
      send_frame(24'h7FFFFF, 24'h800000);
      send_frame('0, 24'hFFFFFF);
   endtask

   // Loud white hiss drives the outputs into saturation.
   task automatic test_white_hiss();
      drain();
      write_reg(REG_NOISE_ENABLE, 24'd1);
      write_reg(REG_HISS_GAIN, 24'd65535);
      send_frame(24'h7FFFFF, 24'h800000);
      send_frame(24'h800000, 24'h7FFFFF);
      send_frame('0, '0);
   endtask

   // Pink only, the pink-only threshold, just under it, and a half blend.
   task automatic test_pink_blend();
      logic [23:0] mixes [4] = '{24'd65535, 24'd65471, 24'd65470, 24'd32768};
      foreach (mixes[i]) begin
         drain();
         write_reg(REG_COLOR_MIX, mixes[i]);
         send_frame(any_sample(), any_sample());
         send_frame(any_sample(), any_sample());
      end
   endtask

   // Shortest gaps, zero length, zero minimum, floor at zero then above unity.
   task automatic test_dropout();
      drain();
      write_reg(REG_NOISE_ENABLE, 24'd0);
      write_reg(REG_DROP_ENABLE, 24'd1);
      write_reg(REG_MEAN_GAP, 24'd1);
      write_reg(REG_MIN_GAP, 24'd0);
      write_reg(REG_DROP_LENGTH, 24'd0);
      write_reg(REG_DROP_FLOOR_GAIN, 24'd0);
      repeat (4) send_frame(24'h7FFFFF, 24'h800000);
      drain();
      write_reg(REG_DROP_FLOOR_GAIN, 24'h1FFFF);
      write_reg(REG_DROP_LENGTH, 24'hFFFFF);
      repeat (3) send_frame(24'h7FFFFF, 24'h800000);
      drain();
      write_reg(REG_MEAN_GAP, 24'hFFFFFF);
      write_reg(REG_MIN_GAP, 24'hFFFFFF);
      write_reg(REG_DROP_ENABLE, 24'd0);
      send_frame(any_sample(), any_sample());
      drain();
      write_reg(REG_DROP_ENABLE, 24'd1);
      send_frame(any_sample(), any_sample());
   endtask

   // Random settings, mostly with short gaps so that dropouts come often.
   task automatic test_random(int items);
      for (int n = 0; n < items; n++) begin
         if (n % 64 == 0) begin
            drain();
            write_reg(REG_NOISE_ENABLE, 24'($urandom_range(3) != 0));
            write_reg(REG_DROP_ENABLE, 24'($urandom_range(3) != 0));
            write_reg(REG_HISS_GAIN,
                      24'($urandom_range(1) ? $urandom : $urandom_range(300)));
            case ($urandom_range(3))
               0: write_reg(REG_COLOR_MIX, 24'd0);
               1: write_reg(REG_COLOR_MIX, 24'd65535);
               default: write_reg(REG_COLOR_MIX, 24'($urandom));
            endcase
            write_reg(REG_DROP_FLOOR_GAIN, 24'($urandom_range(131071)));
            write_reg(REG_DROP_LENGTH,
                      24'($urandom_range(7) == 0 ? $urandom : $urandom_range(40)));
            write_reg(REG_MEAN_GAP,
                      24'($urandom_range(7) == 0 ? $urandom : $urandom_range(120)));
            write_reg(REG_MIN_GAP,
                      24'($urandom_range(7) == 0 ? $urandom : $urandom_range(30)));
         end
         send_frame(any_sample(), any_sample());
      end
   endtask

   initial begin
      cfg_noise = 0; cfg_drop = 0; cfg_hiss = 66; cfg_mix = 0;
      cfg_floor = UNITY; cfg_length = 480; cfg_mean = 24'hFFFFFF; cfg_min = 960;
      lcg = LCG_SEED; gap_count = GAP_IDLE; drop_left = 0; dropping = 0;
      gain_now = UNITY; gain_goal = UNITY;
      foreach (taps[c, k]) taps[c][k] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_passthrough();
      test_white_hiss();
      test_pink_blend();
      test_dropout();

      send_idle_pct = 25; stall_pct = 56;
      test_random(384);
      send_idle_pct = 56; stall_pct = 25;
      test_random(384);
      send_idle_pct = 0; stall_pct = 0;
      test_random(384);

      drain();
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule

// ===== sim.f =====
src/thd_pkg.sv
src/thd_mul.sv
src/tape_hiss_and_dropout.sv
tb/tape_hiss_and_dropout_tb.sv
